// File: design/abdf_pkg.sv
// Shared types, constants and anchor table for the anchor box decode filter.
package abdf_pkg;

    localparam int VALUE_W   = 16;
    localparam int COORD_W   = 10;
    localparam int ROWCNT_W  = 20;
    localparam int POS_W     = 9;
    localparam int ANCHOR_W  = 9;
    localparam int EDGE_W    = 52;

    localparam logic [1:0] CFG_SCORE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_INPUT_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_INPUT_HEIGHT    = 2'd2;
    localparam logic [1:0] CFG_CLASS_COUNT     = 2'd3;

    localparam logic [15:0] THRESHOLD_RESET = 16'd16384;
    localparam logic [12:0] INPUT_W_RESET   = 13'd640;
    localparam logic [12:0] INPUT_H_RESET   = 13'd640;
    localparam logic [7:0]  CLASSES_RESET   = 8'd80;

    // anchor sizes in pixels, [level][anchor]
    localparam logic [ANCHOR_W-1:0] ANCHOR_WIDTHS [3][3] = '{
        '{9'd10,  9'd16,  9'd33},
        '{9'd30,  9'd62,  9'd59},
        '{9'd116, 9'd156, 9'd373}
    };
    localparam logic [ANCHOR_W-1:0] ANCHOR_HEIGHTS [3][3] = '{
        '{9'd13,  9'd30,  9'd23},
        '{9'd61,  9'd45,  9'd119},
        '{9'd90,  9'd198, 9'd326}
    };

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_SCORE     = 4'd1,
        OP_W_SQUARE  = 4'd2,
        OP_W_ANCHOR  = 4'd3,
        OP_H_SQUARE  = 4'd4,
        OP_H_ANCHOR  = 4'd5,
        OP_EDGE_XMIN = 4'd6,
        OP_EDGE_YMIN = 4'd7,
        OP_EDGE_XMAX = 4'd8,
        OP_EDGE_YMAX = 4'd9
    } arith_op_t;

    typedef struct packed {
        logic restart;
        logic advance;
        logic settle;
    } grid_ctrl_t;

    typedef struct packed {
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [1:0]          anchor;
        logic [1:0]          level;
        logic [ROWCNT_W-1:0] row_count;
        logic                active;
        logic                more;
    } grid_stat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] dx;
        logic [VALUE_W-1:0] dy;
        logic [VALUE_W-1:0] dw;
        logic [VALUE_W-1:0] dh;
        logic [VALUE_W-1:0] objectness;
        logic [VALUE_W-1:0] best_score;
        logic [7:0]         best_index;
    } row_data_t;

    typedef struct packed {
        logic signed [15:0] x_min;
        logic signed [15:0] y_min;
        logic signed [15:0] x_max;
        logic signed [15:0] y_max;
    } box_t;

    function automatic logic [ANCHOR_W-1:0] anchor_size(
        input logic [1:0] level,
        input logic [1:0] anchor,
        input logic       height
    );
        logic [ANCHOR_W-1:0] size;
        size = '0;
        if (level < 2'd3 && anchor < 2'd3)
        begin
            size = height ? ANCHOR_HEIGHTS[level][anchor] : ANCHOR_WIDTHS[level][anchor];
        end
        return size;
    endfunction

    // grid extent along one axis at a level: pixels >> (3 + level)
    function automatic logic [COORD_W-1:0] grid_extent(
        input logic [12:0] pixels,
        input logic [1:0]  level
    );
        logic [COORD_W-1:0] ext;
        case (level)
            2'd0:    ext = pixels[12:3];
            2'd1:    ext = {1'b0, pixels[12:4]};
            2'd2:    ext = {2'b0, pixels[12:5]};
            default: ext = '0;
        endcase
        return ext;
    endfunction

endpackage

// File: design/abdf_row_acc.sv
// Row element capture: box offsets, objectness and running class argmax.
module abdf_row_acc #(
    parameter int MAX_CLASSES = 255
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      frame_start,
    input  logic [15:0]               value,
    input  logic [7:0]                class_count,
    output logic                      row_last,
    output abdf_pkg::row_data_t       row_data
);
    import abdf_pkg::*;

    localparam logic [7:0] CLASS_LIMIT = 8'(MAX_CLASSES);

    logic [POS_W-1:0]   pos_reg, pos_next, pos_eff;
    logic [VALUE_W-1:0] offsets_reg [4];
    logic [VALUE_W-1:0] obj_reg;
    logic [VALUE_W-1:0] best_reg;
    logic [7:0]         best_idx_reg;
    logic [7:0]         classes;
    logic [7:0]         k;
    logic               is_class;

    always_comb
    begin
        if (class_count == 8'd0)
            classes = 8'd1;
        else if (class_count > CLASS_LIMIT)
            classes = CLASS_LIMIT;
        else
            classes = class_count;
    end

    assign pos_eff  = frame_start ? '0 : pos_reg;
    assign is_class = pos_eff >= POS_W'(5);
    assign k        = 8'(pos_eff - POS_W'(5));
    assign row_last = is_class && ({1'b0, k} + 9'd1 >= {1'b0, classes});
    assign pos_next = row_last ? '0 : pos_eff + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            offsets_reg  <= '{default: '0};
            obj_reg      <= '0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            if (pos_eff < POS_W'(4))
                offsets_reg[pos_eff[1:0]] <= value;
            else if (pos_eff == POS_W'(4))
                obj_reg <= value;
            else if (k == 8'd0 || value > best_reg)
            begin
                best_reg     <= value;
                best_idx_reg <= k;
            end
        end
    end

    assign row_data.dx         = offsets_reg[0];
    assign row_data.dy         = offsets_reg[1];
    assign row_data.dw         = offsets_reg[2];
    assign row_data.dh         = offsets_reg[3];
    assign row_data.objectness = obj_reg;
    assign row_data.best_score = best_reg;
    assign row_data.best_index = best_idx_reg;

endmodule

// File: design/abdf_grid.sv
// Grid position counters: column, row, anchor, level and row number.
module abdf_grid #(
    parameter int LEVELS            = 3,
    parameter int ANCHORS_PER_LEVEL = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abdf_pkg::grid_ctrl_t ctrl,
    input  logic [12:0]          input_width,
    input  logic [12:0]          input_height,
    output abdf_pkg::grid_stat_t stat
);
    import abdf_pkg::*;

    localparam logic [1:0] LEVEL_END  = 2'(LEVELS);
    localparam logic [2:0] ANCHOR_END = 3'(ANCHORS_PER_LEVEL);

    logic [COORD_W-1:0]  col_reg, row_reg;
    logic [1:0]          anchor_reg, level_reg;
    logic [ROWCNT_W-1:0] rcnt_reg;

    logic [COORD_W-1:0] gw, gh;
    logic [COORD_W-1:0] s_col;
    logic [COORD_W:0]   s_row;
    logic [2:0]         s_anchor;
    logic [1:0]         s_level;
    logic               s_more;
    logic               active;

    assign active = level_reg < LEVEL_END;
    assign gw     = grid_extent(input_width, level_reg);
    assign gh     = grid_extent(input_height, level_reg);

    // one pass of the settle loop
    always_comb
    begin
        s_col    = col_reg;
        s_row    = {1'b0, row_reg};
        s_anchor = {1'b0, anchor_reg};
        s_level  = level_reg;
        s_more   = 1'b0;
        if (active)
        begin
            if (gw == '0 || gh == '0)
            begin
                s_col    = '0;
                s_row    = '0;
                s_anchor = '0;
                s_level  = level_reg + 2'd1;
                s_more   = 1'b1;
            end
            else
            begin
                if (s_col >= gw)
                begin
                    s_col = '0;
                    s_row = s_row + 11'd1;
                end
                if (s_row >= {1'b0, gh})
                begin
                    s_row    = '0;
                    s_anchor = s_anchor + 3'd1;
                end
                if (s_anchor >= ANCHOR_END)
                begin
                    s_anchor = '0;
                    s_level  = level_reg + 2'd1;
                    s_more   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            anchor_reg <= '0;
            level_reg  <= '0;
            rcnt_reg   <= '0;
        end
        else if (ctrl.restart)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            anchor_reg <= '0;
            level_reg  <= '0;
            rcnt_reg   <= '0;
        end
        else if (ctrl.advance)
        begin
            rcnt_reg <= rcnt_reg + ROWCNT_W'(1);
            if (active)
                col_reg <= col_reg + COORD_W'(1);
        end
        else if (ctrl.settle)
        begin
            col_reg    <= s_col;
            row_reg    <= s_row[COORD_W-1:0];
            anchor_reg <= s_anchor[1:0];
            level_reg  <= s_level;
        end
    end

    assign stat.col       = col_reg;
    assign stat.row       = row_reg;
    assign stat.anchor    = anchor_reg;
    assign stat.level     = level_reg;
    assign stat.row_count = rcnt_reg;
    assign stat.active    = active;
    assign stat.more      = s_more;

endmodule

// File: design/abdf_arith.sv
// Shared 32x16 multiplier and edge adder/rounder used by the row sequencer.
module abdf_arith (
    input  logic                clk,
    input  abdf_pkg::arith_op_t op,
    input  abdf_pkg::row_data_t row_data,
    input  abdf_pkg::grid_stat_t pos,
    output logic [15:0]         score,
    output abdf_pkg::box_t      box
);
    import abdf_pkg::*;

    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    logic [47:0] prod_reg;
    logic [40:0] hw_reg;
    box_t        box_reg;

    logic                     sel_y, sub;
    logic [VALUE_W-1:0]       off;
    logic [COORD_W-1:0]       coord;
    logic [5:0]               shamt;
    logic signed [EDGE_W-1:0] base, cent, half2, v, rnd;
    logic signed [23:0]       q;
    logic signed [15:0]       edge_q;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            OP_SCORE:
            begin
                mul_a = {16'b0, row_data.objectness};
                mul_b = row_data.best_score;
            end
            OP_W_SQUARE:
            begin
                mul_a = {16'b0, row_data.dw};
                mul_b = row_data.dw;
            end
            OP_W_ANCHOR:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {7'b0, anchor_size(pos.level, pos.anchor, 1'b0)};
            end
            OP_H_SQUARE:
            begin
                mul_a = {16'b0, row_data.dh};
                mul_b = row_data.dh;
            end
            OP_H_ANCHOR:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {7'b0, anchor_size(pos.level, pos.anchor, 1'b1)};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // edges in units of 2^-32 pixel: center = (2d - 0.5 + cell) * stride,
    // half size = 2 * d^2 * anchor
    assign sel_y = (op == OP_EDGE_YMIN) || (op == OP_EDGE_YMAX);
    assign sub   = (op == OP_EDGE_XMIN) || (op == OP_EDGE_YMIN);
    assign off   = sel_y ? row_data.dy : row_data.dx;
    assign coord = sel_y ? pos.row : pos.col;
    assign shamt = 6'd19 + {4'b0, pos.level};

    always_comb
    begin
        base  = $signed({26'b0, coord, 16'b0}) + $signed({35'b0, off, 1'b0})
                - 52'sd32768;
        cent  = base <<< shamt;
        half2 = $signed({10'b0, (sel_y ? prod_reg[40:0] : hw_reg), 1'b0});
        v     = sub ? cent - half2 : cent + half2;
        rnd   = v + 52'sd134217728;
        q     = rnd[51:28];
        if (q > 24'sd32767)
            edge_q = 16'sh7fff;
        else if (q < -24'sd32768)
            edge_q = 16'sh8000;
        else
            edge_q = q[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_SCORE || op == OP_W_SQUARE || op == OP_W_ANCHOR
            || op == OP_H_SQUARE || op == OP_H_ANCHOR)
            prod_reg <= mul_p;
        if (op == OP_H_SQUARE)
            hw_reg <= prod_reg[40:0];
        case (op)
            OP_EDGE_XMIN: box_reg.x_min <= edge_q;
            OP_EDGE_YMIN: box_reg.y_min <= edge_q;
            OP_EDGE_XMAX: box_reg.x_max <= edge_q;
            OP_EDGE_YMAX: box_reg.y_max <= edge_q;
            default:      box_reg <= box_reg;
        endcase
    end

    assign score = prod_reg[31:16];
    assign box   = box_reg;

endmodule

// File: design/anchor_box_decode_filter_core.sv
// Top level: config registers, row sequencer and output register.
//
// Input channel (in_valid/in_ready): one network output value per item, row
// by row; frame_start on an item restarts the row and grid counters.
// Output channel (out_valid/out_ready): one decoded box per kept row.
// Config port: cfg_we writes cfg_data into register cfg_index at once.
//
// Sequencing: an item that does not end a row leaves the block idle, so the
// next item can be taken without a pause. An item that ends a row starts the
// sequencer: score multiply and threshold check, then for a kept row the width
// and height square and anchor multiplies and the x_min, y_min, x_max and y_max
// edges on the one shared multiplier and edge unit plus a load into the output
// register, then the counter update and the settle steps that bring the grid to
// a valid position. in_ready is low during all of this. A frame_start item
// restarts the counters and then runs the settle steps too. The output register
// holds a result until taken; a stalled receiver only blocks the sequencer at
// the load step of the next kept row. Reset restores the register defaults and
// clears all counters; the block is ready as soon as reset is released.
module anchor_box_decode_filter_core #(
    parameter int LEVELS            = 3,
    parameter int ANCHORS_PER_LEVEL = 3,
    parameter int MAX_CLASSES       = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        value,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] x_min,
    output logic signed [15:0] y_min,
    output logic signed [15:0] x_max,
    output logic signed [15:0] y_max,
    output logic [7:0]         class_label,
    output logic [15:0]        score,
    output logic [19:0]        candidate_index
);
    import abdf_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_SETTLE    = 14'b00000000000010,
        ST_SCORE     = 14'b00000000000100,
        ST_CHECK     = 14'b00000000001000,
        ST_W_SQUARE  = 14'b00000000010000,
        ST_W_ANCHOR  = 14'b00000000100000,
        ST_H_SQUARE  = 14'b00000001000000,
        ST_H_ANCHOR  = 14'b00000010000000,
        ST_EDGE_XMIN = 14'b00000100000000,
        ST_EDGE_YMIN = 14'b00001000000000,
        ST_EDGE_XMAX = 14'b00010000000000,
        ST_EDGE_YMAX = 14'b00100000000000,
        ST_EMIT      = 14'b01000000000000,
        ST_ADVANCE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] thr_reg;
    logic [12:0] width_reg, height_reg;
    logic [7:0]  classes_reg;

    logic        accept;
    logic        row_last;
    row_data_t   row_data;
    grid_ctrl_t  grid_ctrl;
    grid_stat_t  grid_stat;
    arith_op_t   op;
    logic [15:0] arith_score;
    box_t        box;

    logic        out_valid_reg, out_valid_next;
    logic        load;
    box_t        box_out_reg;
    logic [7:0]  label_reg;
    logic [15:0] score_reg, score_out_reg;
    logic [19:0] cand_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESHOLD_RESET;
            width_reg   <= INPUT_W_RESET;
            height_reg  <= INPUT_H_RESET;
            classes_reg <= CLASSES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCORE_THRESHOLD: thr_reg     <= cfg_data;
                CFG_INPUT_WIDTH:     width_reg   <= cfg_data[12:0];
                CFG_INPUT_HEIGHT:    height_reg  <= cfg_data[12:0];
                CFG_CLASS_COUNT:     classes_reg <= cfg_data[7:0];
                default:             thr_reg     <= thr_reg;
            endcase
        end
    end

    abdf_row_acc #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_row_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (frame_start),
        .value       (value),
        .class_count (classes_reg),
        .row_last    (row_last),
        .row_data    (row_data)
    );

    abdf_grid #(
        .LEVELS            (LEVELS),
        .ANCHORS_PER_LEVEL (ANCHORS_PER_LEVEL)
    ) u_grid (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (grid_ctrl),
        .input_width  (width_reg),
        .input_height (height_reg),
        .stat         (grid_stat)
    );

    abdf_arith u_arith (
        .clk      (clk),
        .op       (op),
        .row_data (row_data),
        .pos      (grid_stat),
        .score    (arith_score),
        .box      (box)
    );

    always_comb
    begin
        state_next        = state_reg;
        op                = OP_NONE;
        grid_ctrl.restart = 1'b0;
        grid_ctrl.advance = 1'b0;
        grid_ctrl.settle  = 1'b0;
        load              = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (frame_start)
                    begin
                        grid_ctrl.restart = 1'b1;
                        state_next        = ST_SETTLE;
                    end
                    else if (row_last)
                    begin
                        state_next = ST_SCORE;
                    end
                end
            end
            ST_SETTLE:
            begin
                grid_ctrl.settle = 1'b1;
                if (!grid_stat.more)
                    state_next = ST_IDLE;
            end
            ST_SCORE:
            begin
                op         = OP_SCORE;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (grid_stat.active && arith_score > thr_reg)
                    state_next = ST_W_SQUARE;
                else
                    state_next = ST_ADVANCE;
            end
            ST_W_SQUARE:
            begin
                op         = OP_W_SQUARE;
                state_next = ST_W_ANCHOR;
            end
            ST_W_ANCHOR:
            begin
                op         = OP_W_ANCHOR;
                state_next = ST_H_SQUARE;
            end
            ST_H_SQUARE:
            begin
                op         = OP_H_SQUARE;
                state_next = ST_H_ANCHOR;
            end
            ST_H_ANCHOR:
            begin
                op         = OP_H_ANCHOR;
                state_next = ST_EDGE_XMIN;
            end
            ST_EDGE_XMIN:
            begin
                op         = OP_EDGE_XMIN;
                state_next = ST_EDGE_YMIN;
            end
            ST_EDGE_YMIN:
            begin
                op         = OP_EDGE_YMIN;
                state_next = ST_EDGE_XMAX;
            end
            ST_EDGE_XMAX:
            begin
                op         = OP_EDGE_XMAX;
                state_next = ST_EDGE_YMAX;
            end
            ST_EDGE_YMAX:
            begin
                op         = OP_EDGE_YMAX;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                grid_ctrl.advance = 1'b1;
                state_next        = ST_SETTLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CHECK)
            score_reg <= arith_score;
        if (load)
        begin
            box_out_reg   <= box;
            label_reg     <= row_data.best_index;
            score_out_reg <= score_reg;
            cand_reg      <= grid_stat.row_count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign x_min           = box_out_reg.x_min;
    assign y_min           = box_out_reg.y_min;
    assign x_max           = box_out_reg.x_max;
    assign y_max           = box_out_reg.y_max;
    assign class_label     = label_reg;
    assign score           = score_out_reg;
    assign candidate_index = cand_reg;

endmodule

// File: bench/tb_top.sv
// Testbench for anchor_box_decode_filter_core: directed rows, then random rows checked by a model.
module tb_top;
    import abdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_WAIT    = 40;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int QUIET_TAIL     = 600;

    // anchor (width, height) in pixels, level by level
    localparam int unsigned ANCHOR_PX [18] = '{
        10, 13, 16, 30, 33, 23,
        30, 61, 62, 45, 59, 119,
        116, 90, 156, 198, 373, 326
    };

    typedef struct packed {
        logic [15:0] x_min;
        logic [15:0] y_min;
        logic [15:0] x_max;
        logic [15:0] y_max;
        logic [7:0]  label;
        logic [15:0] conf;
        logic [19:0] row_idx;
    } decoded_box_t;

    typedef enum logic { STEP_ITEM, STEP_CFG } step_kind_t;

    typedef struct packed {
        step_kind_t   kind;
        logic [1:0]   sel;
        logic [15:0]  data;
        logic         fs;
        logic         pinned;
        decoded_box_t box;
    } script_step_t;

    localparam decoded_box_t NO_BOX = '0;
    // centered box of zero size at cell 0, full confidence
    localparam decoded_box_t BOX_ORIGIN = '{16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd65534, 20'd0};

    localparam script_step_t SCRIPT [30] = '{
        '{STEP_CFG,  CFG_CLASS_COUNT, 16'd0,     1'b0, 1'b0, NO_BOX},
        // default grid, one class, zero-size box at the origin
        '{STEP_ITEM, '0,              16'd16384, 1'b1, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd16384, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b1, BOX_ORIGIN},
        // confidence equal to threshold: dropped
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd32768, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd32768, 1'b0, 1'b0, NO_BOX},
        // one step above threshold, full-scale offsets
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd32768, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd32770, 1'b0, 1'b0, NO_BOX},
        // three classes, tie on the first two, count drops to one mid-row
        '{STEP_CFG,  CFG_CLASS_COUNT, 16'd3,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd1000,  1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd30000, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd0,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd65535, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd40000, 1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd40000, 1'b0, 1'b0, NO_BOX},
        '{STEP_CFG,  CFG_CLASS_COUNT, 16'd1,     1'b0, 1'b0, NO_BOX},
        '{STEP_ITEM, '0,              16'd100,   1'b0, 1'b0, NO_BOX},
        '{STEP_CFG,  CFG_SCORE_THRESHOLD, 16'd16384, 1'b0, 1'b0, NO_BOX}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        value;
    logic               frame_start;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] x_min;
    logic signed [15:0] y_min;
    logic signed [15:0] x_max;
    logic signed [15:0] y_max;
    logic [7:0]         class_label;
    logic [15:0]        score;
    logic [19:0]        candidate_index;

    anchor_box_decode_filter_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .x_min           (x_min),
        .y_min           (y_min),
        .x_max           (x_max),
        .y_max           (y_max),
        .class_label     (class_label),
        .score           (score),
        .candidate_index (candidate_index)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    decoded_box_t expected_boxes[$];
    int           mismatches = 0;
    int           items_sent = 0;
    bit           tx_idle_on = 1'b0;
    bit           rx_idle_on = 1'b0;

    // decoder state as the block should hold it
    int unsigned  thr_q, width_px, height_px, classes_cfg;
    int unsigned  elem_pos, obj_q, best_q, best_k;
    int unsigned  g_col, g_row, anc_no, lvl_no;
    logic [15:0]  offs [4];
    logic [19:0]  row_no;

    function automatic void settle_grid();
        int unsigned ncol, nrow;
        while (lvl_no < 3)
        begin
            ncol = width_px / (8 << lvl_no);
            nrow = height_px / (8 << lvl_no);
            if (ncol == 0 || nrow == 0)
            begin
                g_col = 0;
                g_row = 0;
                anc_no = 0;
                lvl_no++;
                continue;
            end
            if (g_col >= ncol)
            begin
                g_col = 0;
                g_row++;
            end
            if (g_row >= nrow)
            begin
                g_row = 0;
                anc_no++;
            end
            if (anc_no >= 3)
            begin
                anc_no = 0;
                lvl_no++;
                continue;
            end
            break;
        end
    endfunction

    function automatic void restart_grid();
        elem_pos = 0;
        g_col = 0;
        g_row = 0;
        anc_no = 0;
        lvl_no = 0;
        row_no = '0;
        settle_grid();
    endfunction

    function automatic void reset_decoder();
        thr_q = THRESHOLD_RESET;
        width_px = INPUT_W_RESET;
        height_px = INPUT_H_RESET;
        classes_cfg = CLASSES_RESET;
        foreach (offs[i])
            offs[i] = '0;
        obj_q = 0;
        best_q = 0;
        best_k = 0;
        restart_grid();
    endfunction

    function automatic void store_reg(input logic [1:0] sel, input logic [15:0] data);
        case (sel)
            CFG_SCORE_THRESHOLD: thr_q = data;
            CFG_INPUT_WIDTH:     width_px = data[12:0];
            CFG_INPUT_HEIGHT:    height_px = data[12:0];
            CFG_CLASS_COUNT:     classes_cfg = data[7:0];
            default: ;
        endcase
    endfunction

    // v in 2^-32 pixel units -> Q12.4, round half up, saturate
    function automatic logic [15:0] to_q12_4(input longint v);
        longint r;
        r = (v + (longint'(1) <<< 27)) >>> 28;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic bit predict_item(input logic [15:0] v, input bit fs,
                                        output decoded_box_t b);
        int unsigned n_cls, k, conf, s, ai;
        longint      cx, cy, hw, hh, aw, ah;
        bit          last, hit;
        n_cls = (classes_cfg == 0) ? 1 : classes_cfg;
        last = 1'b0;
        hit = 1'b0;
        b = NO_BOX;
        if (fs)
            restart_grid();
        if (elem_pos < 4)
            offs[elem_pos] = v;
        else if (elem_pos == 4)
            obj_q = v;
        else
        begin
            k = elem_pos - 5;
            if (k == 0 || v > best_q)
            begin
                best_q = v;
                best_k = k & 8'hFF;
            end
            last = (k + 1 >= n_cls);
        end
        if (last)
        begin
            conf = (obj_q * best_q) >> 16;
            if (lvl_no < 3 && conf > thr_q)
            begin
                hit = 1'b1;
                s = 8 << lvl_no;
                ai = (lvl_no * 6 + anc_no * 2) % 18;
                aw = ANCHOR_PX[ai];
                ah = ANCHOR_PX[ai + 1];
                cx = (2 * longint'(offs[0]) - 32768 + longint'(g_col) * 65536) * s * 65536;
                cy = (2 * longint'(offs[1]) - 32768 + longint'(g_row) * 65536) * s * 65536;
                hw = longint'(offs[2]) * longint'(offs[2]) * aw * 2;
                hh = longint'(offs[3]) * longint'(offs[3]) * ah * 2;
                b.x_min = to_q12_4(cx - hw);
                b.y_min = to_q12_4(cy - hh);
                b.x_max = to_q12_4(cx + hw);
                b.y_max = to_q12_4(cy + hh);
                b.label = best_k[7:0];
                b.conf = conf[15:0];
                b.row_idx = row_no;
            end
            elem_pos = 0;
            row_no++;
            if (lvl_no < 3)
            begin
                g_col++;
                settle_grid();
            end
        end
        else
            elem_pos++;
        return hit;
    endfunction

    function automatic int row_len();
        return ((classes_cfg == 0) ? 1 : classes_cfg) + 5;
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(49152, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_value(input logic [15:0] v, input bit fs, input bit pinned,
                              input decoded_box_t pinned_box);
        decoded_box_t got;
        bit           hit;
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hit = predict_item(v, fs, got);
        if (pinned)
            expected_boxes.push_back(pinned_box);
        else if (hit)
            expected_boxes.push_back(got);
        items_sent++;
    endtask

    // one row of random content; ties and out-of-place frame starts now and then
    task automatic push_row(input bit fs_first, input int count);
        logic [15:0] v, prev_cls;
        bit          fs;
        prev_cls = '0;
        for (int e = 0; e < count; e++)
        begin
            if (e < 4)
                v = rand_value();
            else if (e == 4)
                v = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(32768, 65535))
                                               : rand_value();
            else if (e > 5 && $urandom_range(0, 3) == 0)
                v = prev_cls;
            else
                v = rand_value();
            if (e >= 5)
                prev_cls = v;
            fs = (e == 0) ? fs_first : ($urandom_range(0, 199) == 0);
            push_value(v, fs, 1'b0, NO_BOX);
        end
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        @(posedge clk);
        store_reg(sel, data);
    endtask

    task automatic program_setting(input logic [15:0] thr, input logic [15:0] w,
                                   input logic [15:0] h, input logic [15:0] n_cls);
        write_reg(CFG_SCORE_THRESHOLD, thr);
        write_reg(CFG_INPUT_WIDTH, w);
        write_reg(CFG_INPUT_HEIGHT, h);
        write_reg(CFG_CLASS_COUNT, n_cls);
        cfg_we <= 1'b0;
    endtask

    // wait for all boxes, then for a dropped row still in flight
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_box
        decoded_box_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                $error("box for row %0d with none expected", candidate_index);
                mismatches++;
            end
            else
            begin
                want = expected_boxes.pop_front();
                check_field("x_min", $signed(want.x_min), x_min);
                check_field("y_min", $signed(want.y_min), y_min);
                check_field("x_max", $signed(want.x_max), x_max);
                check_field("y_max", $signed(want.y_max), y_max);
                check_field("class_label", want.label, class_label);
                check_field("score", want.conf, score);
                check_field("candidate_index", want.row_idx, candidate_index);
            end
        end
    end

    initial
    begin : receiver
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int          rand_start, phase_start, budget;
        bit          first, quiet_tail;
        logic [15:0] thr;
        logic [12:0] w_px, h_px;
        logic [7:0]  n_cls;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        value <= '0;
        frame_start <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SCORE_THRESHOLD;
        cfg_data <= '0;
        reset_decoder();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == STEP_CFG)
            begin
                settle_idle();
                write_reg(SCRIPT[i].sel, SCRIPT[i].data);
                cfg_we <= 1'b0;
            end
            else
                push_value(SCRIPT[i].data, SCRIPT[i].fs, SCRIPT[i].pinned, SCRIPT[i].box);
        end

        // one-row strip, widest grid: send 250 rows with nothing kept, then keep six
        // more cells; the random frame starts in those rows can restart the walk
        settle_idle();
        program_setting(16'hFFFF, 16'hFFFF, 16'd8, 16'd1);
        for (int r = 0; r < 250; r++)
            push_row(r == 0, row_len());
        settle_idle();
        program_setting(16'h0000, 16'hFFFF, 16'd8, 16'd1);
        for (int r = 0; r < 6; r++)
        begin
            push_value(16'd65535, 1'b0, 1'b0, NO_BOX);
            push_value(16'd32768, 1'b0, 1'b0, NO_BOX);
            push_value(16'd65535, 1'b0, 1'b0, NO_BOX);
            push_value(16'd0, 1'b0, 1'b0, NO_BOX);
            push_value(16'd65535, 1'b0, 1'b0, NO_BOX);
            push_value(16'd65535, 1'b0, 1'b0, NO_BOX);
        end

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            quiet_tail = (items_sent - rand_start) > RANDOM_ITEMS - QUIET_TAIL;
            settle_idle();
            case ($urandom_range(0, 5))
                0:       thr = 16'h0000;
                1:       thr = 16'hFFFF;
                2:       thr = 16'($urandom);
                default: thr = 16'($urandom_range(0, 40000));
            endcase
            case ($urandom_range(0, 9))
                0:
                begin
                    w_px = 13'h1FFF;
                    h_px = 13'h1FFF;
                end
                1:
                begin
                    w_px = 13'd4096;
                    h_px = 13'd32;
                end
                2:
                begin
                    w_px = 13'd32;
                    h_px = 13'd32;
                end
                3:
                begin
                    // some or all levels empty
                    w_px = 13'($urandom_range(0, 40));
                    h_px = 13'($urandom_range(0, 40));
                end
                default:
                begin
                    w_px = 13'($urandom_range(8, 96));
                    h_px = 13'($urandom_range(8, 96));
                end
            endcase
            case ($urandom_range(0, 9))
                0:       n_cls = 8'd0;
                1:       n_cls = 8'd255;
                2:       n_cls = CLASSES_RESET;
                3:       n_cls = 8'd1;
                default: n_cls = 8'($urandom_range(1, 6));
            endcase
            program_setting(thr, {3'($urandom), w_px}, {3'($urandom), h_px},
                            {8'($urandom), n_cls});
            tx_idle_on = !quiet_tail && $urandom_range(0, 3) != 0;
            rx_idle_on = !quiet_tail && $urandom_range(0, 3) != 0;
            budget = $urandom_range(40, 300);
            phase_start = items_sent;
            first = $urandom_range(0, 1);
            // a phase may stop mid-row, so the next setting lands mid-row or mid-frame
            while (items_sent - phase_start < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_row(first, $urandom_range(1, row_len()));
                else
                    push_row(first, row_len());
                first = 1'b0;
            end
        end

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        settle_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
